@@ hdl/lbp3_pkg.sv @@
// ----------------------------------------------------------------------------
// lbp3_pkg
// Shared widths, register codes and the LBP code function for the 3x3
// local binary pattern transform.
// ----------------------------------------------------------------------------
package lbp3_pkg;

  localparam int PIX_W         = 8;
  localparam int CODE_W        = 8;
  localparam int COL_OUT_W     = 10;
  localparam int ROW_OUT_W     = 12;
  localparam int FRAME_W_W     = 11;
  localparam int FRAME_H_W     = 13;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RESET_WIDTH   = 1024;
  localparam int RESET_HEIGHT  = 1024;
  localparam int MIN_DIM       = 3;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 8'd0,
    CFG_FRAME_HEIGHT = 8'd1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // Neighbors in code order, MSB first:
  // (r+1,c+1) (r+1,c) (r+1,c-1) (r,c-1) (r-1,c-1) (r-1,c) (r-1,c+1) (r,c+1)
  function automatic logic [CODE_W-1:0] lbp_code(input pix_t centre,
                                                 input pix_t nb [CODE_W]);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int i = 0; i < CODE_W; i++) begin
      code[CODE_W-1-i] = (centre < nb[i]);
    end
    return code;
  endfunction

endpackage

@@ hdl/lbp_3x3_transform.sv @@
// ----------------------------------------------------------------------------
// lbp_3x3_transform
// 3x3 local binary pattern transform on a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_* channel, one transfer per cycle at
// most. Every interior pixel gives one code on the out_* channel with its
// column and row in the output frame (two smaller than the input in each
// direction); frame_end_o marks the code of the frame's last pixel. Border
// pixels of rows 0 and 1 and columns 0 and 1 give no transfer.
// A pixel passes through stage 1 and the output register. Throughput: one
// pixel per cycle while out_stall_i is low. Each pixel makes one read and
// one write of the line memory (one port each), which sets that figure.
// The line memory holds both previous rows in one word per column; it is read
// when a pixel is taken and written back one stage later.
// Configuration: frame_width (index 0) and frame_height (index 1) on the
// cfg_* channel, always ready; a write to either restarts the frame position.
// Write only while the block is idle. Out-of-range values saturate.
// Reset: position to frame start, window cleared, width min(1024, MAX_WIDTH),
// height 1024. The line memory is not cleared. When out_stall_i is high, the
// output register holds and one more pixel may enter before in_stall_o rises.
// ----------------------------------------------------------------------------
module lbp_3x3_transform #(
  parameter int MAX_WIDTH = lbp3_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lbp3_pkg::PIX_W-1:0]        pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lbp3_pkg::CODE_W-1:0]       code_o,
  output logic [lbp3_pkg::COL_OUT_W-1:0]    out_col_o,
  output logic [lbp3_pkg::ROW_OUT_W-1:0]    out_row_o,
  output logic                              frame_end_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lbp3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbp3_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lbp3_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = FRAME_H_W;
  localparam int RW  = ROW_OUT_W;
  localparam int RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;

  // configuration, stored saturated
  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [FRAME_W_W-1:0] cfg_w_raw;
  logic [WW-1:0] cfg_w_sat;
  logic [HW-1:0] cfg_h_sat;
  logic cfg_xfer;

  // frame position of the next pixel
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // stage 1
  logic          s1_valid_q, s1_valid_d;
  pix_t          s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_prod_q;
  logic          s1_last_q;
  logic [COL_OUT_W-1:0] s1_ocol_q;
  logic [RW-1:0]        s1_orow_q;

  // line memory: {row r-2, row r-1} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic in_xfer, adv, s1_go;
  logic col_last, row_last, prod, last;
  logic [31:0] col_diff, row_diff;
  logic [CODE_W-1:0] code_w;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign cfg_w_raw   = cfg_data_i[FRAME_W_W-1:0];

  always_comb begin
    if (cfg_w_raw < FRAME_W_W'(MIN_DIM)) begin
      cfg_w_sat = WW'(MIN_DIM);
    end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
      cfg_w_sat = WW'(MAX_WIDTH);
    end else begin
      cfg_w_sat = WW'(cfg_w_raw);
    end
    if (cfg_data_i < HW'(MIN_DIM)) begin
      cfg_h_sat = HW'(MIN_DIM);
    end else if (cfg_data_i > HW'(MAX_HEIGHT)) begin
      cfg_h_sat = HW'(MAX_HEIGHT);
    end else begin
      cfg_h_sat = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RST_W);
      height_q <= HW'(RESET_HEIGHT);
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_w_sat;
        CFG_FRAME_HEIGHT: height_q <= cfg_h_sat;
        default: ;
      endcase
    end
  end

  // pipeline control
  assign adv        = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = s1_valid_q & ~adv;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign s1_go      = s1_valid_q & adv;

  // stage 0: position bookkeeping
  assign col_last = (WW'(col_q) + WW'(1)) >= width_q;
  assign row_last = ({1'b0, row_q} + HW'(1)) >= height_q;
  assign prod     = (col_q >= CW'(2)) && (row_q >= RW'(2));
  assign last     = col_last & row_last;
  assign col_diff = 32'(col_q) - 32'd2;
  assign row_diff = 32'(row_q) - 32'd2;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_xfer) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    if (cfg_xfer && (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT)) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line memory: read on pixel transfer, write back as stage 1 moves on
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_go) begin
      line_mem[s1_col_q] <= {rd_q[PIX_W-1:0], s1_pix_q};
    end
  end

  assign s1_valid_d = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_q;
      s1_prod_q <= prod;
      s1_last_q <= last;
      s1_ocol_q <= col_diff[COL_OUT_W-1:0];
      s1_orow_q <= row_diff[RW-1:0];
    end
  end

  // stage 1: window shift and code
  lbp3_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(s1_go),
    .top_i  (rd_q[2*PIX_W-1:PIX_W]),
    .mid_i  (rd_q[PIX_W-1:0]),
    .bot_i  (s1_pix_q),
    .code_o (code_w)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= s1_go & s1_prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_prod_q) begin
      code_o      <= code_w;
      out_col_o   <= s1_ocol_q;
      out_row_o   <= s1_orow_q;
      frame_end_o <= s1_last_q;
    end
  end

endmodule

@@ hdl/lbp3_window.sv @@
// ----------------------------------------------------------------------------
// lbp3_window
// 3x3 pixel window. Shifts in one column per step and gives the LBP code of
// the window centre as it stands after the shift.
// ----------------------------------------------------------------------------
module lbp3_window (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  lbp3_pkg::pix_t        top_i,
  input  lbp3_pkg::pix_t        mid_i,
  input  lbp3_pkg::pix_t        bot_i,
  output logic [lbp3_pkg::CODE_W-1:0] code_o
);
  import lbp3_pkg::*;

  // row major, top row first, newest column last
  pix_t win_q [9];
  pix_t win_d [9];
  pix_t nb [CODE_W];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3 + 0] = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = bot_i;
  end

  always_comb begin
    nb[0] = win_d[8];
    nb[1] = win_d[7];
    nb[2] = win_d[6];
    nb[3] = win_d[3];
    nb[4] = win_d[0];
    nb[5] = win_d[1];
    nb[6] = win_d[2];
    nb[7] = win_d[5];
  end

  assign code_o = lbp_code(win_d[4], nb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 LBP transform: raster pixels go in, every
// interior code with its output position and frame-end flag is predicted in
// a scoreboard and compared field by field as it leaves, under random idling
// on both channels and a set of frame sizes that includes the smallest frame
// and saturated sizes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lbp3_pkg::*;

  localparam int CLK_PERIOD        = 8;
  localparam int RESET_CYCLES      = 6;
  localparam int DRAIN_CYCLES      = 4;        // pipeline drain plus margin
  localparam int LONG_HOLD         = 300;
  localparam int RANDOM_ITEMS      = 1500;
  localparam int CFG_UNKNOWN_FIRST = 2;
  localparam int CFG_UNKNOWN_LAST  = 2**CFG_IDX_W - 1;
  localparam longint TIMEOUT_NS    = 64'd10_000_000;

  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic                 frame_end;
  } lbp_result_t;

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_NEAR} pix_mode_e;

  // Predicts the code stream from accepted pixels and checks received codes.
  class lbp_scoreboard;
    pix_t          line_prev  [MAX_WIDTH_DEF];
    pix_t          line_prev2 [MAX_WIDTH_DEF];
    pix_t          win [3][3];
    int unsigned   col_pos;
    int unsigned   row_pos;
    int unsigned   width_reg;
    int unsigned   height_reg;
    lbp_result_t   expected_q [$];
    int unsigned   errors;

    function new();
      foreach (line_prev[i]) begin
        line_prev[i]  = '0;
        line_prev2[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      errors     = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH) width_reg = data[FRAME_W_W-1:0];
      else if (idx == CFG_FRAME_HEIGHT) height_reg = data[FRAME_H_W-1:0];
      else return;
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void note_pixel(pix_t pix);
      int unsigned w;
      int unsigned h;
      pix_t        top;
      pix_t        mid;
      pix_t        centre;
      pix_t        ring [8];
      lbp_result_t res;
      w   = eff_width();
      h   = eff_height();
      top = line_prev2[col_pos];
      mid = line_prev[col_pos];
      line_prev2[col_pos] = mid;
      line_prev[col_pos]  = pix;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = pix;
      if (row_pos >= 2 && col_pos >= 2) begin
        centre = win[1][1];
        // neighbors MSB first, starting below-right and going clockwise
        ring = '{win[2][2], win[2][1], win[2][0], win[1][0],
                 win[0][0], win[0][1], win[0][2], win[1][2]};
        for (int i = 0; i < CODE_W; i++) res.code[CODE_W-1-i] = (centre < ring[i]);
        res.col       = COL_OUT_W'(col_pos - 2);
        res.row       = ROW_OUT_W'(row_pos - 2);
        res.frame_end = (row_pos == h - 1 && col_pos == w - 1);
        expected_q.insert(expected_q.size(), res);
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    function void check_code(lbp_result_t got);
      lbp_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected code transfer: code=%02h col=%0d row=%0d frame_end=%0b",
               got.code, got.col, got.row, got.frame_end);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.code != want.code) begin
        $error("code: expected %02h, actual %02h (col %0d row %0d)",
               want.code, got.code, want.col, want.row);
        errors++;
      end
      if (got.col != want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, got.col);
        errors++;
      end
      if (got.row != want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, got.row);
        errors++;
      end
      if (got.frame_end != want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b (col %0d row %0d)",
               want.frame_end, got.frame_end, want.col, want.row);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  pix_t                  pixel_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CODE_W-1:0]     code_o;
  logic [COL_OUT_W-1:0]  out_col_o;
  logic [ROW_OUT_W-1:0]  out_row_o;
  logic                  frame_end_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  lbp_scoreboard sb = new();
  int unsigned   src_idle_pct  = 0;
  int unsigned   snk_idle_pct  = 0;
  int unsigned   n_sent        = 0;
  int unsigned   base_level    = 0;
  logic          long_hold_req = 1'b0;
  pix_t          extreme_levels [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

  lbp_3x3_transform u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_o      (code_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .frame_end_o (frame_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic pix_t next_pixel(pix_mode_e mode);
    case (mode)
      PIX_EXTREME: return extreme_levels[$urandom_range(0, 3)];
      PIX_NEAR:    return pix_t'(base_level + $urandom_range(0, 2));
      default:     return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input pix_t pix);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(pix);
    n_sent++;
  endtask

  task automatic stop_pixels();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_empty();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // pixels on the border leave no trace at the output, so give the pipe time
  task automatic wait_drained();
    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_burst(input int n, input pix_mode_e mode, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        stop_pixels();
        wait_empty();
      end
      send_pixel(next_pixel(mode));
    end
    stop_pixels();
  endtask

  task automatic run_phase();
    int unsigned           wv;
    int unsigned           hv;
    int unsigned           w;
    int unsigned           h;
    int unsigned           area;
    int                    n;
    int                    pause_at;
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] hdata;
    pix_mode_e             mode;
    case ($urandom_range(0, 15))
      0:       wv = $urandom_range(0, MIN_DIM - 1);
      1:       wv = $urandom_range(MAX_WIDTH_DEF + 1, 2**FRAME_W_W - 1);
      default: wv = $urandom_range(MIN_DIM, 12);
    endcase
    case ($urandom_range(0, 15))
      0:       hv = $urandom_range(0, MIN_DIM - 1);
      1:       hv = $urandom_range(MAX_HEIGHT + 1, 2**FRAME_H_W - 1);
      default: hv = $urandom_range(MIN_DIM, 8);
    endcase
    // bits above the width field are dropped by the block
    wdata = CFG_DATA_W'(wv + ($urandom_range(0, 3) << FRAME_W_W));
    hdata = CFG_DATA_W'(hv);
    wait_drained();
    if ($urandom_range(0, 3) == 0)
      write_cfg(CFG_IDX_W'($urandom_range(CFG_UNKNOWN_FIRST, CFG_UNKNOWN_LAST)),
                CFG_DATA_W'($urandom));
    case ($urandom_range(0, 9))
      0: ;  // carry on from wherever the frame stands
      1: write_cfg(CFG_FRAME_WIDTH, wdata);
      2: write_cfg(CFG_FRAME_HEIGHT, hdata);
      3, 4: begin
        write_cfg(CFG_FRAME_HEIGHT, hdata);
        write_cfg(CFG_FRAME_WIDTH, wdata);
      end
      default: begin
        write_cfg(CFG_FRAME_WIDTH, wdata);
        write_cfg(CFG_FRAME_HEIGHT, hdata);
      end
    endcase
    w    = sb.eff_width();
    h    = sb.eff_height();
    area = w * h;
    if (area <= 256)
      n = $urandom_range(1, 3) * area +
          (($urandom_range(0, 2) == 0) ? $urandom_range(1, area - 1) : 0);
    else if (w == MAX_WIDTH_DEF)
      n = $urandom_range(1, 60);
    else
      n = $urandom_range(2 * w, 20 * w);
    mode       = pix_mode_e'($urandom_range(0, 2));
    base_level = $urandom_range(0, 255);
    pause_at   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
    send_burst(n, mode, pause_at);
  endtask

  // receiver stall; a long hold-off is counted here when requested
  initial begin : sink_stall
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < snk_idle_pct);
      end
    end
  end

  initial begin : sink_check
    lbp_result_t got;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.code      = code_o;
        got.col       = out_col_o;
        got.row       = out_row_o;
        got.frame_end = frame_end_o;
        sb.check_code(got);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    pix_t        ring_hi [9];
    pix_t        ring_lo [9];
    pix_t        mixed   [9];
    int unsigned seg_stop;

    ring_hi = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
                8'd255, 8'd255, 8'd255, 8'd255};
    ring_lo = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
                8'd0, 8'd0, 8'd0, 8'd0};
    mixed   = '{8'd100, 8'd101, 8'd99, 8'd100, 8'd100,
                8'd255, 8'd1, 8'd101, 8'd100};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sizes out of reset: part of row 0, nothing may come out
    send_burst(RESET_WIDTH / 8, PIX_UNIFORM, -1);

    // smallest frame, reached through saturating writes
    wait_drained();
    write_cfg(CFG_FRAME_WIDTH, '0);
    write_cfg(CFG_FRAME_HEIGHT, CFG_DATA_W'(MIN_DIM - 1));
    foreach (ring_hi[i]) send_pixel(ring_hi[i]);
    foreach (ring_lo[i]) send_pixel(ring_lo[i]);
    // a write to an unused index mid-frame must not restart the frame
    foreach (mixed[i]) begin
      if (i == 4) begin
        stop_pixels();
        wait_drained();
        write_cfg(CFG_IDX_W'(CFG_UNKNOWN_LAST), '1);
      end
      send_pixel(mixed[i]);
    end
    for (int i = 0; i < 3; i++) send_pixel(extreme_levels[i]);
    stop_pixels();

    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin src_idle_pct = 27; snk_idle_pct = 49; end
        1: begin src_idle_pct = 49; snk_idle_pct = 27; end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          // fill the block against a stalled receiver
          wait_drained();
          write_cfg(CFG_FRAME_WIDTH, CFG_DATA_W'(MIN_DIM));
          write_cfg(CFG_FRAME_HEIGHT, CFG_DATA_W'(8));
          long_hold_req = 1'b1;
          send_burst(2 * MIN_DIM * 8, PIX_UNIFORM, -1);
        end
      endcase
      seg_stop = n_sent + RANDOM_ITEMS / 3;
      while (n_sent < seg_stop) run_phase();
    end

    wait_drained();
    if (sb.pending() != 0) begin
      $error("%0d codes never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
